[src/gbeg_pkg.sv]
// Shared types and constants for the elevation grid interpolator.
package gbeg_pkg;

    localparam int IDX_W  = 12;
    localparam int SMP_W  = 32;
    localparam int FRAC_W = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_INV_X    = 3'd2;
    localparam logic [2:0] CFG_INV_Y    = 3'd3;
    localparam logic [2:0] CFG_COLS     = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        inv_x;
        logic [31:0]        inv_y;
        logic [8:0]         cols;
        logic [8:0]         rows;
    } t_cfg;

    typedef struct packed {
        logic                    op;
        logic                    outside;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
        logic [FRAC_W-1:0]       frac_a;
        logic [FRAC_W-1:0]       frac_b;
        logic signed [SMP_W-1:0] value;
    } t_cmd;

endpackage

[src/grid_bilinear_elevation_gradient.sv]
// Top level: elevation grid with bilinear interpolation and gradient.
// Load beats write one grid sample through the grid memory port; a query inside the grid
// reads its four cell corners through the single memory port, one per cycle, and no
// new command is taken from the queue until those corner reads are issued.
// Input beats are taken every cycle while the four-entry command queue has room.
// Grid entries read before being loaded return unspecified data.
module grid_bilinear_elevation_gradient #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [7:0]         i_load_col,
    input  logic [7:0]         i_load_row,
    input  logic signed [23:0] i_load_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_elevation_out,
    output logic signed [47:0] o_grad_x_out,
    output logic signed [47:0] o_grad_y_out,
    output logic               o_outside_flag
);

    gbeg_pkg::t_cfg r_cfg;
    gbeg_pkg::t_cmd f_cmd;
    gbeg_pkg::t_cmd q_cmd;
    logic           f_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.inv_x    <= 32'd16777216;
            r_cfg.inv_y    <= 32'd16777216;
            r_cfg.cols     <= 9'd256;
            r_cfg.rows     <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbeg_pkg::CFG_ORIGIN_X: r_cfg.origin_x <= $signed(i_cfg_data);
                gbeg_pkg::CFG_ORIGIN_Y: r_cfg.origin_y <= $signed(i_cfg_data);
                gbeg_pkg::CFG_INV_X:    r_cfg.inv_x    <= i_cfg_data;
                gbeg_pkg::CFG_INV_Y:    r_cfg.inv_y    <= i_cfg_data;
                gbeg_pkg::CFG_COLS:     r_cfg.cols     <= i_cfg_data[8:0];
                gbeg_pkg::CFG_ROWS:     r_cfg.rows     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    gbeg_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_load_col   (i_load_col),
        .i_load_row   (i_load_row),
        .i_load_value (i_load_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_push       (f_push),
        .o_cmd        (f_cmd),
        .i_full       (q_full)
    );

    gbeg_fifo #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gbeg_back #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_elevation_out (o_elevation_out),
        .o_grad_x_out    (o_grad_x_out),
        .o_grad_y_out    (o_grad_y_out),
        .o_outside_flag  (o_outside_flag)
    );

endmodule

[src/gbeg_ram.sv]
// Single-port RAM with registered read.
module gbeg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/gbeg_fifo.sv]
// Short command queue between the front and back sections.
module gbeg_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gbeg_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output gbeg_pkg::t_cmd  o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    gbeg_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (32'(p) == DEPTH - 1) ? '0 : p + AW'(1);
        return q;
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[src/gbeg_front.sv]
// Front section: accepts beats, locates the grid cell, and queues commands.
module gbeg_front #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbeg_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [7:0]         i_load_col,
    input  logic [7:0]         i_load_row,
    input  logic signed [23:0] i_load_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    output logic               o_push,
    output gbeg_pkg::t_cmd     o_cmd,
    input  logic               i_full
);

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);

    logic en;

    // stage 1
    logic               r1_v;
    logic               r1_op;
    logic               r1_keep;
    logic [7:0]         r1_col;
    logic [7:0]         r1_row;
    logic signed [31:0] r1_val;
    logic [31:0]        r1_dx;
    logic [31:0]        r1_dy;
    logic               r1_nx;
    logic               r1_ny;

    // stage 2
    logic               r2_v;
    logic               r2_op;
    logic               r2_keep;
    logic [7:0]         r2_col;
    logic [7:0]         r2_row;
    logic signed [31:0] r2_val;
    logic [63:0]        r2_px;
    logic [63:0]        r2_py;
    logic               r2_nx;
    logic               r2_ny;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               n_keep;
    logic [CNW-1:0]     ncx;
    logic [RNW-1:0]     ncy;
    logic [23:0]        cx;
    logic [23:0]        cy;
    logic               outx;
    logic               outy;

    assign en         = !(r2_v && r2_keep && i_full);
    assign o_in_stall = !en;

    assign dx = 33'(i_pos_x) - 33'(i_cfg.origin_x);
    assign dy = 33'(i_pos_y) - 33'(i_cfg.origin_y);

    assign n_keep = (i_op == gbeg_pkg::OP_QUERY) ||
                    ((32'(i_load_col) < MAX_COLS) && (32'(i_load_row) < MAX_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_op;
            r1_keep <= n_keep;
            r1_col  <= i_load_col;
            r1_row  <= i_load_row;
            r1_val  <= 32'(i_load_value);
            r1_dx   <= dx[32] ? 32'd0 : dx[31:0];
            r1_dy   <= dy[32] ? 32'd0 : dy[31:0];
            r1_nx   <= dx[32] && (i_cfg.inv_x != 32'd0);
            r1_ny   <= dy[32] && (i_cfg.inv_y != 32'd0);

            r2_op   <= r1_op;
            r2_keep <= r1_keep;
            r2_col  <= r1_col;
            r2_row  <= r1_row;
            r2_val  <= r1_val;
            r2_px   <= 64'(r1_dx) * 64'(i_cfg.inv_x);
            r2_py   <= 64'(r1_dy) * 64'(i_cfg.inv_y);
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
        end
    end

    assign ncx = (32'(i_cfg.cols) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(i_cfg.cols);
    assign ncy = (32'(i_cfg.rows) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(i_cfg.rows);
    assign cx  = r2_px[63:40];
    assign cy  = r2_py[63:40];

    assign outx = (32'(ncx) < 32'd2) || r2_nx || ((25'(cx) + 25'd1) >= 25'(ncx));
    assign outy = (32'(ncy) < 32'd2) || r2_ny || ((25'(cy) + 25'd1) >= 25'(ncy));

    assign o_push = r2_v && r2_keep && !i_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = r2_op;
        o_cmd.value   = r2_val;
        if (r2_op == gbeg_pkg::OP_LOAD) begin
            o_cmd.col = gbeg_pkg::IDX_W'(r2_col);
            o_cmd.row = gbeg_pkg::IDX_W'(r2_row);
        end else begin
            o_cmd.col     = gbeg_pkg::IDX_W'(cx);
            o_cmd.row     = gbeg_pkg::IDX_W'(cy);
            o_cmd.outside = outx || outy;
            o_cmd.frac_a  = r2_px[39:24];
            o_cmd.frac_b  = r2_py[39:24];
        end
    end

endmodule

[src/gbeg_back.sv]
// Back section: grid memory access, corner gather and interpolation datapath.
module gbeg_back #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbeg_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  gbeg_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_elevation_out,
    output logic signed [47:0] o_grad_x_out,
    output logic signed [47:0] o_grad_y_out,
    output logic               o_outside_flag
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(MAX_COLS * MAX_ROWS);
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DW  = SB + 2;
    localparam int PW  = SB + 19;
    localparam int VW  = PW + 19;
    localparam int EW  = (VW - 32 > 25) ? VW - 32 : 25;
    localparam int MW  = (PW + 1 > 33) ? PW + 1 : 33;

    localparam logic signed [EW-1:0] E_MAX = EW'(8388607);
    localparam logic signed [EW-1:0] E_MIN = EW'(-8388608);
    localparam logic [48:0]          R_LIM = 49'h1 << 47;

    logic en;
    logic full;
    logic hand;
    logic slot_free;

    // read sequencer
    logic           r_rd;
    logic [1:0]     r_k;
    logic [CW-1:0]  r_qc;
    logic [RW-1:0]  r_qr;
    logic [15:0]    r_qa;
    logic [15:0]    r_qb;
    logic           r_capv;
    logic [1:0]     r_capk;
    logic           r_last;
    logic           r_cv;
    logic           r_hout;
    logic [15:0]    r_ha;
    logic [15:0]    r_hb;
    logic signed [SB-1:0] r_ca;
    logic signed [SB-1:0] r_cb;
    logic signed [SB-1:0] r_cc;
    logic signed [SB-1:0] r_cd;

    logic           is_load;
    logic           pop_in;
    logic           pop_out;
    logic           iss_v;
    logic [1:0]     iss_k;
    logic [CW-1:0]  iss_c;
    logic [RW-1:0]  iss_r;
    logic           ram_en;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [SB-1:0]  ram_wdata;
    logic [SB-1:0]  ram_rdata;
    logic signed [SB-1:0] h_d;

    // datapath
    logic                 r_s1v, r_s2v, r_s3v, r_s4v, r_s5v, r_ov;
    logic                 r_s1o, r_s2o, r_s3o, r_s4o, r_s5o;
    logic [15:0]          r_s1a, r_s2a, r_s3a;
    logic [15:0]          r_s1b;
    logic signed [DW-1:0] r_s1_ea, r_s1_ed, r_s1_dba, r_s1_dcd, r_s1_dda, r_s1_ddx, r_s1_ddy;
    logic signed [PW-1:0] r_s2_r0, r_s2_r1, r_s2_sx, r_s2_sy;
    logic signed [PW-1:0] r_s3_r0;
    logic signed [PW:0]   r_s3_dr;
    logic [MW-1:0]        r_s3_mx, r_s3_my;
    logic                 r_s3_nx, r_s3_ny, r_s4_nx, r_s4_ny, r_s5_nx, r_s5_ny;
    logic signed [VW-1:0] r_s4_v;
    logic [MW-1:0]        r_s4_hx, r_s4_hy;
    logic [63:0]          r_s4_lx, r_s4_ly;
    logic signed [23:0]   r_s5_e;
    logic [48:0]          r_s5_rx, r_s5_ry;

    logic signed [23:0]   r_o_e;
    logic signed [47:0]   r_o_gx;
    logic signed [47:0]   r_o_gy;
    logic                 r_o_out;

    logic signed [DW-1:0]   ea, eb, ec, ed, dba, dcd, dda, dcb;
    logic signed [DW+16:0]  p_r0, p_r1, p_sx, p_sy;
    logic signed [PW+17:0]  p_v;
    logic signed [VW-1:0]   ev;
    logic signed [EW-1:0]   e_full;
    logic [48:0]            rx_sum, ry_sum;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
        logic [AW-1:0] a;
        a = AW'(32'(r) * MAX_COLS + 32'(c));
        return a;
    endfunction

    function automatic logic [MW-1:0] f_abs(input logic signed [PW-1:0] s);
        logic signed [PW:0] w;
        logic [MW-1:0]      m;
        w = (PW+1)'(s);
        m = s[PW-1] ? MW'($unsigned(-w)) : MW'($unsigned(w));
        return m;
    endfunction

    function automatic logic [47:0] f_sat(input logic [48:0] r, input logic neg);
        logic [47:0] g;
        if (neg) begin
            g = (r >= R_LIM) ? 48'h8000_0000_0000 : 48'(-r);
        end else begin
            g = (r >= R_LIM) ? 48'h7FFF_FFFF_FFFF : r[47:0];
        end
        return g;
    endfunction

    assign en        = !r_ov || !i_out_stall;
    assign full      = r_last || r_cv;
    assign hand      = en && full;
    assign slot_free = !full || en;

    assign is_load = (i_cmd.op == gbeg_pkg::OP_LOAD);
    assign o_pop   = !r_rd && i_q_valid && (is_load || slot_free);
    assign pop_in  = o_pop && !is_load && !i_cmd.outside;
    assign pop_out = o_pop && !is_load && i_cmd.outside;

    always_comb begin
        iss_v = 1'b0;
        iss_k = 2'd0;
        iss_c = r_qc;
        iss_r = r_qr;
        if (r_rd) begin
            iss_v = 1'b1;
            iss_k = r_k;
        end else if (pop_in) begin
            iss_v = 1'b1;
            iss_c = CW'(i_cmd.col);
            iss_r = RW'(i_cmd.row);
        end
    end

    always_comb begin
        ram_en    = iss_v;
        ram_we    = 1'b0;
        ram_wdata = i_cmd.value[SB-1:0];
        case (iss_k)
            2'd0:    ram_addr = f_addr(iss_c, iss_r);
            2'd1:    ram_addr = f_addr(iss_c, iss_r + RW'(1));
            2'd2:    ram_addr = f_addr(iss_c + CW'(1), iss_r + RW'(1));
            default: ram_addr = f_addr(iss_c + CW'(1), iss_r);
        endcase
        if (o_pop && is_load) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = f_addr(CW'(i_cmd.col), RW'(i_cmd.row));
        end
    end

    gbeg_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_COLS * MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign h_d = r_last ? $signed(ram_rdata) : r_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= 1'b0;
            r_k    <= 2'd0;
            r_capv <= 1'b0;
            r_capk <= 2'd0;
            r_last <= 1'b0;
            r_cv   <= 1'b0;
        end else begin
            r_capv <= iss_v && (iss_k != 2'd3);
            r_capk <= iss_k;
            r_last <= iss_v && (iss_k == 2'd3);
            if (r_rd) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_rd <= 1'b0;
                end
            end else if (pop_in) begin
                r_rd <= 1'b1;
                r_k  <= 2'd1;
            end
            if (pop_out || (r_last && !en)) begin
                r_cv <= 1'b1;
            end else if (hand) begin
                r_cv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_in) begin
            r_qc <= CW'(i_cmd.col);
            r_qr <= RW'(i_cmd.row);
            r_qa <= i_cmd.frac_a;
            r_qb <= i_cmd.frac_b;
        end
        if (r_rd && (r_k == 2'd3)) begin
            r_hout <= 1'b0;
            r_ha   <= r_qa;
            r_hb   <= r_qb;
        end else if (pop_out) begin
            r_hout <= 1'b1;
        end
        if (r_capv) begin
            case (r_capk)
                2'd0:    r_ca <= $signed(ram_rdata);
                2'd1:    r_cb <= $signed(ram_rdata);
                default: r_cc <= $signed(ram_rdata);
            endcase
        end
        if (r_last && !en) begin
            r_cd <= $signed(ram_rdata);
        end
    end

    assign ea  = DW'(r_ca);
    assign eb  = DW'(r_cb);
    assign ec  = DW'(r_cc);
    assign ed  = DW'(h_d);
    assign dba = eb - ea;
    assign dcd = ec - ed;
    assign dda = ed - ea;
    assign dcb = ec - eb;

    assign p_r0 = r_s1_dba * $signed({1'b0, r_s1b});
    assign p_r1 = r_s1_dcd * $signed({1'b0, r_s1b});
    assign p_sx = r_s1_ddx * $signed({1'b0, r_s1b});
    assign p_sy = r_s1_ddy * $signed({1'b0, r_s1a});
    assign p_v  = r_s3_dr * $signed({1'b0, r_s3a});

    assign ev     = r_s4_v + (VW'(1) <<< 31);
    assign e_full = EW'(ev >>> 32);
    assign rx_sum = (49'(r_s4_hx[30:0]) << 16) + 49'(r_s4_lx[63:16]);
    assign ry_sum = (49'(r_s4_hy[30:0]) << 16) + 49'(r_s4_ly[63:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
            r_s4v <= 1'b0;
            r_s5v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_s1v <= hand;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;
            r_s4v <= r_s3v;
            r_s5v <= r_s4v;
            r_ov  <= r_s5v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1o    <= r_hout;
            r_s1a    <= r_ha;
            r_s1b    <= r_hb;
            r_s1_ea  <= ea;
            r_s1_ed  <= ed;
            r_s1_dba <= dba;
            r_s1_dcd <= dcd;
            r_s1_dda <= dda;
            r_s1_ddx <= dcb - dda;
            r_s1_ddy <= dcd - dba;

            r_s2o   <= r_s1o;
            r_s2a   <= r_s1a;
            r_s2_r0 <= (PW'(r_s1_ea) <<< 16) + PW'(p_r0);
            r_s2_r1 <= (PW'(r_s1_ed) <<< 16) + PW'(p_r1);
            r_s2_sx <= (PW'(r_s1_dda) <<< 16) + PW'(p_sx);
            r_s2_sy <= (PW'(r_s1_dba) <<< 16) + PW'(p_sy);

            r_s3o   <= r_s2o;
            r_s3a   <= r_s2a;
            r_s3_r0 <= r_s2_r0;
            r_s3_dr <= (PW+1)'(r_s2_r1) - (PW+1)'(r_s2_r0);
            r_s3_mx <= f_abs(r_s2_sx);
            r_s3_my <= f_abs(r_s2_sy);
            r_s3_nx <= r_s2_sx[PW-1];
            r_s3_ny <= r_s2_sy[PW-1];

            r_s4o   <= r_s3o;
            r_s4_v  <= (VW'(r_s3_r0) <<< 16) + VW'(p_v);
            r_s4_hx <= MW'(r_s3_mx[MW-1:32] * i_cfg.inv_x);
            r_s4_hy <= MW'(r_s3_my[MW-1:32] * i_cfg.inv_y);
            r_s4_lx <= 64'(r_s3_mx[31:0]) * 64'(i_cfg.inv_x);
            r_s4_ly <= 64'(r_s3_my[31:0]) * 64'(i_cfg.inv_y);
            r_s4_nx <= r_s3_nx;
            r_s4_ny <= r_s3_ny;

            r_s5o   <= r_s4o;
            r_s5_nx <= r_s4_nx;
            r_s5_ny <= r_s4_ny;
            if (e_full > E_MAX) begin
                r_s5_e <= 24'sh7FFFFF;
            end else if (e_full < E_MIN) begin
                r_s5_e <= -24'sh800000;
            end else begin
                r_s5_e <= 24'(e_full);
            end
            r_s5_rx <= (r_s4_hx >= (MW'(1) << 31)) ? R_LIM : rx_sum;
            r_s5_ry <= (r_s4_hy >= (MW'(1) << 31)) ? R_LIM : ry_sum;

            r_o_out <= r_s5o;
            r_o_e   <= r_s5o ? 24'sd0 : r_s5_e;
            r_o_gx  <= r_s5o ? 48'sd0 : $signed(f_sat(r_s5_rx, r_s5_nx));
            r_o_gy  <= r_s5o ? 48'sd0 : $signed(f_sat(r_s5_ry, r_s5_ny));
        end
    end

    assign o_out_valid     = r_ov;
    assign o_elevation_out = r_o_e;
    assign o_grad_x_out    = r_o_gx;
    assign o_grad_y_out    = r_o_gy;
    assign o_outside_flag  = r_o_out;

endmodule

[dv/tb_grid_bilinear_elevation_gradient.sv]
// Testbench for the elevation grid interpolator: self-checking with a predictor.
module tb_grid_bilinear_elevation_gradient;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [23:0] elev;
        logic signed [47:0] gx;
        logic signed [47:0] gy;
        logic               outside;
    } t_sample_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = gbeg_pkg::CFG_ORIGIN_X;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_op = gbeg_pkg::OP_LOAD;
    logic [7:0]         i_load_col = '0;
    logic [7:0]         i_load_row = '0;
    logic signed [23:0] i_load_value = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [23:0] o_elevation_out;
    logic signed [47:0] o_grad_x_out;
    logic signed [47:0] o_grad_y_out;
    logic               o_outside_flag;

    grid_bilinear_elevation_gradient dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic signed [23:0] grid_mem [0:65535];
    bit                 loaded [0:65535];
    logic [31:0]        m_ox = 0, m_oy = 0, m_ix = 32'h0100_0000, m_iy = 32'h0100_0000;
    logic [8:0]         m_cols = 9'd256, m_rows = 9'd256;
    t_sample_out        pending_q [$];
    int                 errors = 0;
    bit                 quiet = 1'b0;
    int                 hold_cycles = 0;
    int                 stall_burst = 0;
    int                 sent_beats = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit locate_axis(input logic [31:0] pos, input logic [31:0] org,
                                       input logic [31:0] inv, input logic [8:0] cnt,
                                       output int idx, output int frac);
        longint      n;
        longint      d;
        logic [63:0] p;
        logic [63:0] c;
        n = (cnt > 256) ? 256 : cnt;
        d = longint'($signed(pos)) - longint'($signed(org));
        idx = 0;
        frac = 0;
        if (n < 2) return 1'b0;
        if (d < 0) begin
            if (inv != 0) return 1'b0;
            d = 0;
        end
        p = d * {32'b0, inv};
        c = p >> 40;
        if (c + 1 >= n) return 1'b0;
        idx = int'(c);
        frac = int'(p[39:24]);
        return 1'b1;
    endfunction

    function automatic logic [47:0] slope_scale(input longint s, input logic [31:0] inv);
        logic [63:0] m, hi, r, lim;
        bit          neg;
        lim = 64'd1 << 47;
        neg = s < 0;
        m = neg ? -s : s;
        hi = (m >> 32) * {32'b0, inv};
        if (hi >= (64'd1 << 31)) r = lim;
        else r = (hi << 16) + (({32'b0, m[31:0]} * {32'b0, inv}) >> 16);
        if (neg) return (r >= lim) ? 48'(-lim) : 48'(-r);
        return (r >= lim) ? 48'(lim - 1) : 48'(r);
    endfunction

    function automatic longint corner(input int col, input int row);
        return longint'(grid_mem[row * 256 + col]);
    endfunction

    function automatic t_sample_out interpolate(input logic [31:0] px, input logic [31:0] py);
        t_sample_out res;
        int          i, j, a, b;
        longint      ca, cb, cc, cd, r0, r1, v, e, sx, sy;
        res = '{elev: 0, gx: 0, gy: 0, outside: 1'b1};
        if (!locate_axis(px, m_ox, m_ix, m_cols, i, a)) return res;
        if (!locate_axis(py, m_oy, m_iy, m_rows, j, b)) return res;
        ca = corner(i, j);
        cb = corner(i, j + 1);
        cc = corner(i + 1, j + 1);
        cd = corner(i + 1, j);
        r0 = (65536 - b) * ca + b * cb;
        r1 = (65536 - b) * cd + b * cc;
        v = (65536 - a) * r0 + a * r1;
        e = (v + (64'sd1 <<< 31)) >>> 32;
        if (e > 8388607) e = 8388607;
        if (e < -8388608) e = -8388608;
        sx = (65536 - b) * (cd - ca) + b * (cc - cb);
        sy = (65536 - a) * (cb - ca) + a * (cc - cd);
        res.elev = e[23:0];
        res.gx = slope_scale(sx, m_ix);
        res.gy = slope_scale(sy, m_iy);
        res.outside = 1'b0;
        return res;
    endfunction

    // one input beat; optional random gap before it
    task automatic send_beat(input logic op, input logic [7:0] col, input logic [7:0] row,
                             input logic [23:0] val, input logic [31:0] px,
                             input logic [31:0] py);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_op = op;
        i_load_col = col;
        i_load_row = row;
        i_load_value = val;
        i_pos_x = px;
        i_pos_y = py;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent_beats++;
        if (op == gbeg_pkg::OP_LOAD) begin
            grid_mem[row * 256 + col] = val;
            loaded[row * 256 + col] = 1'b1;
        end else begin
            pending_q.push_back(interpolate(px, py));
        end
    endtask

    task automatic send_load(input int col, input int row, input logic [23:0] val);
        send_beat(gbeg_pkg::OP_LOAD, col[7:0], row[7:0], val, $urandom, $urandom);
    endtask

    // fills any unloaded corner of the target cell first
    task automatic send_query(input logic [31:0] px, input logic [31:0] py);
        int i, j, a, b;
        if (locate_axis(px, m_ox, m_ix, m_cols, i, a) &&
            locate_axis(py, m_oy, m_iy, m_rows, j, b)) begin
            if (!loaded[j * 256 + i]) send_load(i, j, 24'($urandom));
            if (!loaded[(j + 1) * 256 + i]) send_load(i, j + 1, 24'($urandom));
            if (!loaded[(j + 1) * 256 + i + 1]) send_load(i + 1, j + 1, 24'($urandom));
            if (!loaded[j * 256 + i + 1]) send_load(i + 1, j, 24'($urandom));
        end
        send_beat(gbeg_pkg::OP_QUERY, 8'($urandom), 8'($urandom), 24'($urandom), px, py);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        case (idx)
            gbeg_pkg::CFG_ORIGIN_X: m_ox = data;
            gbeg_pkg::CFG_ORIGIN_Y: m_oy = data;
            gbeg_pkg::CFG_INV_X:    m_ix = data;
            gbeg_pkg::CFG_INV_Y:    m_iy = data;
            gbeg_pkg::CFG_COLS:     m_cols = data[8:0];
            gbeg_pkg::CFG_ROWS:     m_rows = data[8:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] ix, input logic [31:0] iy,
                            input logic [31:0] cols, input logic [31:0] rows);
        drain();
        write_reg(gbeg_pkg::CFG_ORIGIN_X, ox);
        write_reg(gbeg_pkg::CFG_ORIGIN_Y, oy);
        write_reg(gbeg_pkg::CFG_INV_X, ix);
        write_reg(gbeg_pkg::CFG_INV_Y, iy);
        write_reg(gbeg_pkg::CFG_COLS, cols);
        write_reg(gbeg_pkg::CFG_ROWS, rows);
    endtask

    // position along one axis, mostly inside the grid
    function automatic logic [31:0] pick_pos(input logic [31:0] org, input logic [31:0] inv,
                                             input logic [8:0] cnt);
        logic [63:0] span;
        logic [63:0] off;
        int          n;
        n = (cnt > 256) ? 256 : int'(cnt);
        if (n < 2 || $urandom_range(0, 9) == 0) return $urandom;
        if (inv == 0) return org + $urandom_range(0, 1000);
        span = (64'(n - 1) << 40) / inv;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        off = {$urandom, $urandom} % (span + 1);
        return org + off[31:0];
    endfunction

    // count is in input beats, corner preloads included
    task automatic random_items(input int count);
        int stop;
        stop = sent_beats + count;
        while (sent_beats < stop) begin
            if ($urandom_range(0, 4) == 0)
                send_load($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
            else
                send_query(pick_pos(m_ox, m_ix, m_cols), pick_pos(m_oy, m_iy, m_rows));
        end
    endtask

    task automatic test_default_grid();
        send_load(0, 0, 24'sh800000);
        send_load(1, 0, 24'sh7FFFFF);
        send_load(0, 1, 24'sh7FFFFF);
        send_load(1, 1, 24'sh800000);
        send_load(255, 255, 24'sh7FFFFF);
        send_query(32'd0, 32'd0);
        send_query(32'd128, 32'd64);
        send_query(32'd255, 32'd255);
        send_query(32'hFFFF_FFFF, 32'd10);
        send_query(32'd10, 32'hFFFF_FFFF);
        send_query(32'd254 * 256 + 255, 32'd254 * 256 + 255);
        send_query(32'd255 * 256, 32'd5);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_extreme_config();
        set_grid(32'h8000_0000, 32'h7FFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 2);
        send_query(32'h8000_0000, 32'h7FFF_FF00);
        send_query(32'h8000_0080, 32'h7FFF_FF40);
        send_query(32'h8000_0100, 32'h7FFF_FF00);
        set_grid(32'd100, 32'd100, 32'd0, 32'd0, 256, 256);
        send_query(32'd0, 32'd50);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 1, 0);
        send_query(32'd10, 32'd10);
        set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 511, 300);
        send_query(32'd255 * 256 - 1, 32'd255 * 256 - 1);
        send_query(32'd255 * 256, 32'd3);
    endtask

    task automatic test_random_grids();
        for (int ph = 0; ph < 5; ph++) begin
            set_grid($urandom, $urandom,
                     (ph == 0) ? 32'h0100_0000 : (32'd1 << $urandom_range(18, 31)),
                     (ph < 3) ? (32'd1 << $urandom_range(18, 31)) : $urandom,
                     (ph == 4) ? 32'd400 : $urandom_range(2, 256), $urandom_range(2, 256));
            random_items(85);
        end
    endtask

    task automatic test_backpressure();
        set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 8, 8);
        random_items(10);
        hold_cycles = 300;
        random_items(50);
    endtask

    task automatic test_no_idling();
        drain();
        quiet = 1'b1;
        random_items(60);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_burst <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_sample_out exp_out;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report("result beat with no query pending");
            end else begin
                exp_out = pending_q.pop_front();
                if (o_outside_flag !== exp_out.outside)
                    report($sformatf("outside %b exp %b", o_outside_flag, exp_out.outside));
                if (o_elevation_out !== exp_out.elev)
                    report($sformatf("elevation %0d exp %0d", o_elevation_out, exp_out.elev));
                if (o_grad_x_out !== exp_out.gx)
                    report($sformatf("grad_x %0d exp %0d", o_grad_x_out, exp_out.gx));
                if (o_grad_y_out !== exp_out.gy)
                    report($sformatf("grad_y %0d exp %0d", o_grad_y_out, exp_out.gy));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_grid();
        test_extreme_config();
        test_random_grids();
        test_backpressure();
        test_no_idling();
        drain();
        repeat (30) @(posedge i_clk);
        if (pending_q.size() != 0) report("queries left without a result");
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #8ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
